### sv/xrg_pkg.sv
package xrg_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;

  // APB register map: one 64-bit register, 8-byte stride
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned REG_SEL_BIT = 3;
  localparam logic REG_IDX_SEED = 1'b0;
  localparam logic [WORD_W-1:0] SEED_RESET = 64'd1;

  // input kinds on s_tuser
  localparam logic OP_RAW = 1'b0;
  localparam logic OP_RANGED = 1'b1;

  // mixer constants
  localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned MIX_SH1 = 30;
  localparam int unsigned MIX_SH2 = 27;
  localparam int unsigned MIX_SH3 = 31;

  // xoshiro256++ constants
  localparam int unsigned ROT_OUT = 23;
  localparam int unsigned ROT_STATE = 45;
  localparam int unsigned SHIFT_T = 17;

  typedef enum logic [3:0] {
    ST_LOAD_A_GO,
    ST_LOAD_A_WAIT,
    ST_LOAD_B_GO,
    ST_LOAD_B_WAIT,
    ST_IDLE,
    ST_SPAN,
    ST_SUM,
    ST_DRAW,
    ST_REDUCE,
    ST_REDUCE2,
    ST_MOD_WAIT,
    ST_CHECK,
    ST_TEST,
    ST_EMIT
  } xrg_state_t;

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                               input int unsigned amt);
    rotl64 = (v << amt) | (v >> (WORD_W - amt));
  endfunction

endpackage

### sv/xoshiro_range_generator.sv
// xoshiro256++ random generator with optional uniform range reduction.
// After reset, and again after each write of the seed register, the four
// 64-bit state words are loaded by chaining a splitmix-style mixer (no
// golden-ratio increment) four times from the seed. The load runs on the
// shared iterative 64-bit multiplier (8 multiplies in all), and s_tready
// stays low meanwhile. s_tready is also held low in the cycle of a seed
// write, so no transaction is taken while the state reloads. A transaction
// on the input stream asks for a raw draw (s_tuser = 0) or a draw in the
// inclusive range [range_min, range_max] (s_tuser = 1); the span wraps
// modulo 2^64, and a span of zero returns the raw draw. One item is worked
// on at a time: a raw draw goes straight to the output register, and a
// ranged draw first passes the reduction and the rejection test. A rejected
// attempt draws again, and every attempt whose draw is at least twice the
// span goes through the bit-serial remainder unit. The result sits in an
// output register, so the next transaction is accepted while it waits.
module xoshiro_range_generator (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [xrg_pkg::ADDR_W-1:0]  paddr,
  input  logic [xrg_pkg::WORD_W-1:0]  pwdata,
  output logic [xrg_pkg::WORD_W-1:0]  prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [2*xrg_pkg::WORD_W-1:0] s_tdata,  // [63:0] range_min, [127:64] range_max
  input  logic                        s_tuser,  // [0] operation
  // output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [xrg_pkg::WORD_W-1:0]  m_tdata   // [63:0] value
);
  import xrg_pkg::*;

  xrg_state_t state;
  xrg_state_t state_next;

  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] gen_words [4];
  logic [WORD_W-1:0] mix_v;
  logic [1:0]        load_idx;

  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] hi;
  logic [WORD_W-1:0] span;
  logic [WORD_W-1:0] limit;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] r;
  logic [WORD_W-1:0] diff;
  logic [WORD_W-1:0] gap;
  logic [WORD_W-1:0] res;
  logic              x_below;
  logic              use_raw;

  // config write
  logic cfg_wr;
  logic seed_wr;

  // shared units
  logic              mul_start;
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic              mul_done;
  logic [WORD_W-1:0] mul_p;
  logic              mod_start;
  logic              mod_done;
  logic [WORD_W-1:0] mod_rem;

  // combinational datapath
  logic [WORD_W-1:0] mix_out;
  logic [WORD_W-1:0] span_calc;
  logic [WORD_W-1:0] x_new;
  logic [WORD_W-1:0] t_word;
  logic [WORD_W-1:0] n0;
  logic [WORD_W-1:0] n1;
  logic [WORD_W-1:0] n2;
  logic [WORD_W-1:0] n3;
  logic [WORD_W:0]   diff_calc;
  logic              in_fire;
  logic              out_load;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign seed_wr = cfg_wr && (paddr[REG_SEL_BIT] == REG_IDX_SEED);
  assign prdata  = (paddr[REG_SEL_BIT] == REG_IDX_SEED) ? seed : '0;

  assign in_fire  = s_tvalid && s_tready;
  assign out_load = (state == ST_EMIT) && (!m_tvalid || m_tready);

  assign mix_out   = mul_p ^ (mul_p >> MIX_SH3);
  assign span_calc = hi - lo + 64'd1;
  assign diff_calc = {1'b0, x} - {1'b0, span};

  // xoshiro256++ output and state advance
  assign x_new  = rotl64(sum, ROT_OUT) + gen_words[0];
  assign t_word = gen_words[1] << SHIFT_T;
  assign n2     = gen_words[2] ^ gen_words[0];
  assign n3     = gen_words[3] ^ gen_words[1];
  assign n1     = gen_words[1] ^ n2;
  assign n0     = gen_words[0] ^ n3;

  xrg_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  xrg_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (x),
    .divisor   (span),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD_A_GO;
    end else if (seed_wr) begin
      state <= ST_LOAD_A_GO;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_start  = 1'b0;
    mul_a      = mix_v ^ (mix_v >> MIX_SH1);
    mul_b      = MIX_MUL_A;
    mod_start  = 1'b0;
    unique case (state)
      ST_LOAD_A_GO: begin
        mul_start  = 1'b1;
        state_next = ST_LOAD_A_WAIT;
      end
      ST_LOAD_A_WAIT: begin
        if (mul_done) begin
          state_next = ST_LOAD_B_GO;
        end
      end
      ST_LOAD_B_GO: begin
        mul_start  = 1'b1;
        mul_a      = mul_p ^ (mul_p >> MIX_SH2);
        mul_b      = MIX_MUL_B;
        state_next = ST_LOAD_B_WAIT;
      end
      ST_LOAD_B_WAIT: begin
        if (mul_done) begin
          state_next = (load_idx == 2'd3) ? ST_IDLE : ST_LOAD_A_GO;
        end
      end
      ST_IDLE: begin
        // a seed write restarts the load chain, so hold off the input
        s_tready = !seed_wr;
        if (s_tvalid) begin
          state_next = (s_tuser == OP_RANGED) ? ST_SPAN : ST_SUM;
        end
      end
      ST_SPAN:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_DRAW;
      ST_DRAW:  state_next = use_raw ? ST_EMIT : ST_REDUCE;
      ST_REDUCE: begin
        state_next = ST_REDUCE2;
      end
      ST_REDUCE2: begin
        // x >= 2*span needs the full remainder
        if (!x_below && (diff >= span)) begin
          mod_start  = 1'b1;
          state_next = ST_MOD_WAIT;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_MOD_WAIT: begin
        if (mod_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: state_next = ST_TEST;
      ST_TEST: begin
        // reject when x - r lands in the biased top slice
        state_next = (gap > limit) ? ST_SUM : ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // seed register and load chain
  always_ff @(posedge clk) begin
    if (rst) begin
      seed     <= SEED_RESET;
      mix_v    <= SEED_RESET;
      load_idx <= 2'd0;
    end else if (seed_wr) begin
      seed     <= pwdata;
      mix_v    <= pwdata;
      load_idx <= 2'd0;
    end else if ((state == ST_LOAD_B_WAIT) && mul_done) begin
      mix_v    <= mix_out;
      load_idx <= load_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_LOAD_B_WAIT) && mul_done && !seed_wr) begin
      gen_words[load_idx] <= mix_out;
    end else if (state == ST_DRAW) begin
      gen_words[0] <= n0;
      gen_words[1] <= n1;
      gen_words[2] <= n2 ^ t_word;
      gen_words[3] <= rotl64(n3, ROT_STATE);
    end
  end

  // draw datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      use_raw <= 1'b1;
    end else if (in_fire) begin
      use_raw <= (s_tuser == OP_RAW);
    end else if (state == ST_SPAN) begin
      use_raw <= (span_calc == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lo <= s_tdata[WORD_W-1:0];
      hi <= s_tdata[2*WORD_W-1:WORD_W];
    end
    if (state == ST_SPAN) begin
      span <= span_calc;
    end
    if (state == ST_SUM) begin
      sum   <= gen_words[0] + gen_words[3];
      limit <= '0 - span;
    end
    if (state == ST_DRAW) begin
      x   <= x_new;
      res <= x_new;
    end
    if (state == ST_REDUCE) begin
      diff    <= diff_calc[WORD_W-1:0];
      x_below <= diff_calc[WORD_W];
    end
    if (state == ST_REDUCE2) begin
      r <= x_below ? x : diff;
    end
    if ((state == ST_MOD_WAIT) && mod_done) begin
      r <= mod_rem;
    end
    if (state == ST_CHECK) begin
      gap <= x - r;
      res <= r + lo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res;
    end
  end

endmodule

### sv/xrg_mul.sv
// 64x64 -> low 64 bits, one 32x32 partial product per cycle.
module xrg_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [xrg_pkg::WORD_W-1:0] op_a,
  input  logic [xrg_pkg::WORD_W-1:0] op_b,
  output logic                      done,
  output logic [xrg_pkg::WORD_W-1:0] product
);
  import xrg_pkg::*;

  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] pp;
  logic [WORD_W-1:0] acc;
  logic [1:0]        step;
  logic              busy;
  logic [HALF_W-1:0] mx;
  logic [HALF_W-1:0] my;

  // step 0: lo*lo, step 1: hi*lo, step 2: lo*hi
  always_comb begin
    unique case (step)
      2'd1: begin
        mx = a[WORD_W-1:HALF_W];
        my = b[HALF_W-1:0];
      end
      2'd2: begin
        mx = a[HALF_W-1:0];
        my = b[WORD_W-1:HALF_W];
      end
      default: begin
        mx = a[HALF_W-1:0];
        my = b[HALF_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= op_a;
      b <= op_b;
    end else if (busy) begin
      pp <= mx * my;
      unique case (step)
        2'd0: acc <= acc;
        2'd1: acc <= pp;
        default: acc <= acc + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
      endcase
    end
  end

  assign product = acc;

endmodule

### sv/xrg_mod.sv
// Restoring remainder, one dividend bit per cycle.
module xrg_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [xrg_pkg::WORD_W-1:0] dividend,
  input  logic [xrg_pkg::WORD_W-1:0] divisor,
  output logic                      done,
  output logic [xrg_pkg::WORD_W-1:0] remainder
);
  import xrg_pkg::*;

  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dsr;
  logic [5:0]        cnt;
  logic              busy;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  assign trial = {rem, quo[WORD_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '1;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[WORD_W-2:0], 1'b0};
      // no borrow: trial >= divisor
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
      end else begin
        rem <= trial[WORD_W-1:0];
      end
    end
  end

  assign remainder = rem;

endmodule

### verif/tb_xoshiro_range_generator.sv
`timescale 1ns / 1ps

module tb_xoshiro_range_generator;
  import xrg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 300;   // long output hold-off
  localparam int unsigned DRAIN_CYCLES = 200;  // idle wait after the final drain
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned ITEMS_PER_PHASE = 300;

  localparam logic [ADDR_W-1:0] SEED_ADDR = ADDR_W'(REG_IDX_SEED) << REG_SEL_BIT;
  // next 8-byte slot: no register there, writes must be dropped
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(1) << REG_SEL_BIT;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam logic [WORD_W-1:0] TOP_BIT = 64'h8000_0000_0000_0000;

  // Expected-value tracker: own xoshiro256++ state, reloaded on each seed write,
  // stepped once per draw attempt of each accepted transaction on the input stream.
  class draw_tracker;
    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] words [4];
    logic [WORD_W-1:0] pending_draws [$];
    int unsigned errors;

    function logic [WORD_W-1:0] mix(logic [WORD_W-1:0] v);
      v = (v ^ (v >> MIX_SH1)) * MIX_MUL_A;
      v = (v ^ (v >> MIX_SH2)) * MIX_MUL_B;
      return v ^ (v >> MIX_SH3);
    endfunction

    function logic [WORD_W-1:0] rot(logic [WORD_W-1:0] v, int unsigned n);
      return (v << n) | (v >> (WORD_W - n));
    endfunction

    function void reseed(logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] v;
      seed_reg = s;
      v = s;
      for (int i = 0; i < 4; i++) begin
        v = mix(v);
        words[i] = v;
      end
    endfunction

    function logic [WORD_W-1:0] next_raw();
      logic [WORD_W-1:0] res;
      logic [WORD_W-1:0] t;
      res = rot(words[0] + words[3], ROT_OUT) + words[0];
      t = words[1] << SHIFT_T;
      words[2] ^= words[0];
      words[3] ^= words[1];
      words[1] ^= words[2];
      words[0] ^= words[3];
      words[2] ^= t;
      words[3] = rot(words[3], ROT_STATE);
      return res;
    endfunction

    // debiased modulo with rejection; span wraps modulo 2^64
    function logic [WORD_W-1:0] next_in_range(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
      logic [WORD_W-1:0] span;
      logic [WORD_W-1:0] bound;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] r;
      span = hi - lo + 64'd1;
      bound = 64'd0 - span;
      if (span == 0) return next_raw();  // full 64-bit span
      forever begin
        x = next_raw();
        r = x;
        if (r >= span) begin
          r -= span;
          if (r >= span) r = r % span;
        end
        if (!((x - r) > bound)) break;
      end
      return r + lo;
    endfunction

    function void note_item(logic op, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
      if (op == OP_RAW) pending_draws.push_back(next_raw());
      else pending_draws.push_back(next_in_range(lo, hi));
    endfunction

    task report(string msg);
      if (errors < 100) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_value(logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (pending_draws.size() == 0) begin
        report($sformatf("unexpected output value %h", got));
      end else begin
        want = pending_draws.pop_front();
        if (got !== want) report($sformatf("value got %h expected %h", got, want));
      end
    endtask

    function int pending();
      return pending_draws.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [WORD_W-1:0] pwdata = '0;
  logic [WORD_W-1:0] prdata;
  logic pready;

  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [2*WORD_W-1:0] s_tdata = '0;  // [63:0] range_min, [127:64] range_max
  logic s_tuser = OP_RAW;             // [0] operation
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;         // [63:0] value

  logic idle_on = 1'b1;      // random bursts of idling on both streams
  logic hold_arm = 1'b0;     // kicks off the long output hold-off
  logic hold_active = 1'b0;
  int unsigned rx_gap = 0;
  int unsigned cyc = 0;

  draw_tracker draws = new();

  xoshiro_range_generator dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Watchdog. Covers the post-reset and post-seed load passes and worst-case
  // rejection retries with plenty of margin.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output side: check every accepted transaction, then decide next cycle's
  // tready, with random stall bursts; the hold-off overrides everything.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) draws.check_value(m_tdata);
      if (hold_active) begin
        m_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        m_tready <= 1'b0;
        rx_gap <= rx_gap - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        rx_gap <= $urandom_range(0, 9);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long hold-off in its own process; the sender keeps offering meanwhile,
  // so the output register fills and the block has to drop s_tready.
  initial begin
    wait (hold_arm);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(input logic op, input logic [WORD_W-1:0] lo,
                           input logic [WORD_W-1:0] hi);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {hi, lo};
    do @(posedge clk); while (!s_tready);
    draws.note_item(op, lo, hi);
  endtask

  // Mostly ranged draws; small spans push every attempt through the remainder
  // unit, spans just past 2^63 force frequent rejections.
  task automatic send_random_item();
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    int unsigned pick;
    lo = rand64();
    hi = rand64();
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_item(OP_RAW, lo, hi);
    end else begin
      if (pick < 55) hi = lo + $urandom_range(0, 1000);
      else if (pick < 70) hi = lo + (rand64() >> $urandom_range(0, 63));
      else if (pick < 75) hi = lo - 64'd1;
      else if (pick < 85) hi = lo + TOP_BIT + $urandom_range(0, 255);
      // otherwise both bounds random, reversed about half the time
      send_item(OP_RANGED, lo, hi);
    end
  endtask

  // Drop valid and wait until every issued transaction has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (draws.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == SEED_ADDR) draws.reseed(data);
  endtask

  task automatic verify_seed_reg();
    logic [WORD_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= SEED_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== draws.seed_reg)
      draws.report($sformatf("seed readback %h expected %h", got, draws.seed_reg));
  endtask

  initial begin
    logic [WORD_W-1:0] phase_seed;
    draws.reseed(SEED_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    verify_seed_reg();

    // Directed, reset seed: field extremes, full span (both the natural and
    // the wrapped form), span of one, reversed bounds, power-of-two spans.
    send_item(OP_RAW, '0, '0);
    send_item(OP_RAW, ALL_ONES, ALL_ONES);
    send_item(OP_RANGED, '0, ALL_ONES);
    send_item(OP_RANGED, 64'd5, 64'd4);
    send_item(OP_RANGED, '0, '0);
    send_item(OP_RANGED, ALL_ONES, ALL_ONES);
    send_item(OP_RANGED, ALL_ONES, '0);
    send_item(OP_RANGED, 64'd100, 64'd3);
    send_item(OP_RANGED, '0, 64'd1);
    send_item(OP_RANGED, '0, 64'd2);
    send_item(OP_RANGED, '0, TOP_BIT - 64'd1);
    send_item(OP_RANGED, '0, TOP_BIT);
    send_item(OP_RANGED, 64'd10, 64'd20);
    send_item(OP_RAW, rand64(), rand64());
    send_item(OP_RANGED, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);

    // write to an unmapped slot: seed and generator state must not change
    drain();
    apb_write(SPARE_ADDR, rand64());
    verify_seed_reg();
    send_item(OP_RAW, '0, '0);
    send_item(OP_RANGED, 64'd1000, 64'd2000);

    // zero seed: state stays all-zero, every draw is 0, ranged gives range_min unless the span is zero
    drain();
    apb_write(SEED_ADDR, '0);
    verify_seed_reg();
    send_item(OP_RAW, ALL_ONES, ALL_ONES);
    send_item(OP_RANGED, '0, ALL_ONES);
    send_item(OP_RANGED, 64'd123, 64'd456);
    send_item(OP_RANGED, ALL_ONES, '0);
    send_item(OP_RANGED, 64'd7, 64'd6);

    // Random phases, each under a fresh seed. Phase 1 carries the hold-off;
    // the last phase runs with both sides at full rate.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          phase_seed = ALL_ONES;
        end
        2: begin
          phase_seed = TOP_BIT;
        end
        default: begin
          phase_seed = rand64();
        end
      endcase
      drain();
      apb_write(SEED_ADDR, phase_seed);
      verify_seed_reg();
      if (p == 1) hold_arm <= 1'b1;
      if (p == RANDOM_PHASES - 1) idle_on <= 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_item();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (draws.pending() != 0)
      draws.report($sformatf("%0d expected values never arrived", draws.pending()));
    if (draws.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
